[rtl/core/hcd_pkg.sv]
// ----------------------------------------------------------------------------
// hcd_pkg
// Shared types, codes and helpers for the chunked transfer decoder.
// ----------------------------------------------------------------------------
package hcd_pkg;

    // Register map (index = paddr[2])
    localparam int unsigned PADDR_W    = 3;
    localparam int unsigned PDATA_W    = 32;
    localparam logic [0:0]  REG_LINE_LEN  = 1'b0;
    localparam logic [0:0]  REG_CHUNK_MAX = 1'b1;

    // Field widths
    localparam int unsigned LINE_W  = 9;
    localparam int unsigned SIZE_W  = 31;
    localparam int unsigned CHUNK_W = 32;
    localparam int unsigned OUT_W   = 48;

    // Reset values of the registers
    localparam logic [LINE_W-1:0] LINE_LEN_RST  = 9'd511;
    localparam logic [SIZE_W-1:0] CHUNK_MAX_RST = 31'h7FFF_FFFF;

    // Characters of interest
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X_UC  = 8'h58;
    localparam logic [7:0] CH_X_LC  = 8'h78;

    // Decoder phase
    typedef enum logic [2:0] {
        PH_LINE = 3'd0,
        PH_DATA = 3'd1,
        PH_SKIP = 3'd2,
        PH_TAIL = 3'd3,
        PH_END  = 3'd4
    } phase_t;

    // Size line parser step
    typedef enum logic [2:0] {
        PS_WS     = 3'd0,
        PS_SIGN   = 3'd1,
        PS_ZERO   = 3'd2,
        PS_ZX     = 3'd3,
        PS_DIGITS = 3'd4,
        PS_DONE   = 3'd5
    } pstep_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_FRAMING = 3'd0,
        ST_PAYLOAD = 3'd1,
        ST_ENDED   = 3'd2,
        ST_BADLINE = 3'd3,
        ST_IGNORED = 3'd4
    } status_t;

    // Parser step plus line flags
    typedef struct packed {
        pstep_t step;
        logic   neg;   // minus seen
        logic   ovf;   // value overflowed 31 bits
        logic   dig;   // at least one digit
        logic   bad;   // sign in first byte
        logic   nul;   // NUL seen, CR LF no longer ends the line
    } parse_t;

    localparam parse_t PARSE_CLR = '{step: PS_WS, neg: 1'b0, ovf: 1'b0,
                                     dig: 1'b0, bad: 1'b0, nul: 1'b0};

    // Hex digit value; bit 4 set means not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        begin
            v = 5'h10;
            if (b >= 8'h30 && b <= 8'h39)
            begin
                v = {1'b0, b[3:0]};
            end
            else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
            begin
                v = {1'b0, b[3:0] + 4'd9};
            end
            return v;
        end
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        begin
            return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
        end
    endfunction

endpackage

[rtl/core/hcd_cfg_regs.sv]
// ----------------------------------------------------------------------------
// hcd_cfg_regs
// APB register block: line length cap and largest chunk size.
// ----------------------------------------------------------------------------
module hcd_cfg_regs
    import hcd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [LINE_W-1:0]  max_line_len,
    output logic [SIZE_W-1:0]  max_chunk_size
);

    logic [LINE_W-1:0] line_len_reg;
    logic [SIZE_W-1:0] chunk_max_reg;
    logic              wr_en;
    logic [0:0]        reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[2];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_len_reg  <= LINE_LEN_RST;
            chunk_max_reg <= CHUNK_MAX_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_LINE_LEN:  line_len_reg  <= pwdata[LINE_W-1:0];
                REG_CHUNK_MAX: chunk_max_reg <= pwdata[SIZE_W-1:0];
                default:       ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        unique case (reg_idx)
            REG_LINE_LEN:  prdata = {{(PDATA_W-LINE_W){1'b0}}, line_len_reg};
            REG_CHUNK_MAX: prdata = {{(PDATA_W-SIZE_W){1'b0}}, chunk_max_reg};
            default:       prdata = '0;
        endcase
    end

    assign max_line_len   = line_len_reg;
    assign max_chunk_size = chunk_max_reg;

endmodule

[rtl/core/hcd_line_parse.sv]
// ----------------------------------------------------------------------------
// hcd_line_parse
// Absorbs one size-line byte: NUL tracking, first-byte sign check and the
// base-16 conversion step with overflow detection.
// ----------------------------------------------------------------------------
module hcd_line_parse
    import hcd_pkg::*;
(
    input  parse_t            parse_in,
    input  logic [SIZE_W-1:0] accum_in,
    input  logic [7:0]        byte_in,
    input  logic              first_byte,
    output parse_t            parse_out,
    output logic [SIZE_W-1:0] accum_out
);

    logic [4:0] hv;
    logic       is_hex;
    logic       take_digit;

    assign hv     = hex_value(byte_in);
    assign is_hex = ~hv[4];

    // step of the conversion
    always_comb
    begin
        parse_out  = parse_in;
        accum_out  = accum_in;
        take_digit = 1'b0;
        if (byte_in == CH_NUL)
        begin
            parse_out.nul = 1'b1;
        end
        else if (!parse_in.nul)
        begin
            if (first_byte && (byte_in == CH_PLUS || byte_in == CH_MINUS))
            begin
                parse_out.bad = 1'b1;
            end
            unique case (parse_in.step)
                PS_WS, PS_SIGN:
                begin
                    if (parse_in.step == PS_WS && is_space(byte_in))
                    begin
                        parse_out.step = parse_in.step;
                    end
                    else if (parse_in.step == PS_WS &&
                             (byte_in == CH_PLUS || byte_in == CH_MINUS))
                    begin
                        if (byte_in == CH_MINUS)
                        begin
                            parse_out.neg = 1'b1;
                        end
                        parse_out.step = PS_SIGN;
                    end
                    else if (byte_in == CH_ZERO)
                    begin
                        parse_out.dig  = 1'b1;
                        parse_out.step = PS_ZERO;
                    end
                    else if (is_hex)
                    begin
                        parse_out.dig  = 1'b1;
                        take_digit     = 1'b1;
                        parse_out.step = PS_DIGITS;
                    end
                    else
                    begin
                        parse_out.step = PS_DONE;
                    end
                end
                PS_ZERO:
                begin
                    if (byte_in == CH_X_LC || byte_in == CH_X_UC)
                    begin
                        parse_out.step = PS_ZX;
                    end
                    else if (is_hex)
                    begin
                        take_digit     = 1'b1;
                        parse_out.step = PS_DIGITS;
                    end
                    else
                    begin
                        parse_out.step = PS_DONE;
                    end
                end
                PS_ZX, PS_DIGITS:
                begin
                    if (is_hex)
                    begin
                        take_digit     = 1'b1;
                        parse_out.step = PS_DIGITS;
                    end
                    else
                    begin
                        parse_out.step = PS_DONE;
                    end
                end
                default:
                begin
                    parse_out.step = PS_DONE;
                end
            endcase
        end

        // accumulate digit; any of the top four bits set means x16 would overflow
        if (take_digit && !parse_in.ovf)
        begin
            if (|accum_in[SIZE_W-1:SIZE_W-4])
            begin
                parse_out.ovf = 1'b1;
            end
            else
            begin
                accum_out = {accum_in[SIZE_W-5:0], hv[3:0]};
            end
        end
    end

endmodule

[rtl/core/http_chunked_decoder_top.sv]
// ----------------------------------------------------------------------------
// http_chunked_decoder_top
// HTTP/1.1 chunked transfer decoder, one raw byte per transaction.
// ----------------------------------------------------------------------------
// Takes one byte of a chunked body per clock while the input is not stalled
// and returns exactly one result transaction per byte: a status code, the
// payload byte, the current chunk size and an end flag. Each byte is decoded
// combinationally from the decoder state registers into an output register,
// and its result appears there in the cycle after the byte is taken; the
// output register can be reloaded in the same cycle that its result is
// taken, and back-pressure only stalls the input while that register is
// full and not being drained. Size lines are parsed as hexadecimal on the
// fly; malformed lines end the stream. The two registers (line length cap,
// largest chunk size) should be written only while the decoder is idle.
// ----------------------------------------------------------------------------
module http_chunked_decoder_top
    import hcd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // input stream
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] in_byte
    // result stream
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [OUT_W-1:0]   m_axis_tdata,   // [2:0] status, [10:3] data_byte,
                                               // [42:11] chunk_size, [43] ended
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [LINE_W-1:0]  max_line_len;
    logic [SIZE_W-1:0]  max_chunk_size;

    // decoder state
    phase_t              phase_reg, phase_next;
    logic [LINE_W-1:0]   line_count_reg, line_count_next;
    logic [SIZE_W-1:0]   accum_reg, accum_next;
    parse_t              parse_reg, parse_next;
    logic                prev_cr_reg, prev_cr_next;
    logic [SIZE_W-1:0]   remaining_reg, remaining_next;
    logic [CHUNK_W-1:0]  cur_size_reg, cur_size_next;
    logic [1:0]          skip_reg, skip_next;
    logic                done_reg, done_next;

    // result register
    logic                out_valid_reg;
    status_t             status_reg, status_next;
    logic [7:0]          data_reg, data_next;

    // parser outputs
    parse_t              parse_byte;
    logic [SIZE_W-1:0]   accum_byte;

    // shared conditions
    logic                accept;
    logic [7:0]          in_byte;
    logic                line_done;
    logic                line_bad;
    logic [LINE_W:0]     line_n;
    logic                cap_hit;
    logic [SIZE_W-1:0]   rem_after;
    logic [1:0]          skip_after;

    hcd_cfg_regs u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .max_line_len   (max_line_len),
        .max_chunk_size (max_chunk_size)
    );

    hcd_line_parse u_parse (
        .parse_in   (parse_reg),
        .accum_in   (accum_reg),
        .byte_in    (in_byte),
        .first_byte (line_count_reg == '0),
        .parse_out  (parse_byte),
        .accum_out  (accum_byte)
    );

    // handshake
    assign s_axis_tready = ~out_valid_reg | m_axis_tready;
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign in_byte       = s_axis_tdata;

    // line completion and checks
    assign line_done  = ~parse_reg.nul & prev_cr_reg & (in_byte == CH_LF);
    assign line_bad   = ~parse_reg.dig | parse_reg.bad | parse_reg.ovf
                        | (parse_reg.neg & (accum_reg != '0))
                        | (accum_reg > max_chunk_size);
    assign line_n     = {1'b0, line_count_reg} + {{LINE_W{1'b0}}, 1'b1};
    assign cap_hit    = line_n >= {1'b0, max_line_len};
    assign rem_after  = (remaining_reg != '0) ? remaining_reg - 1'b1 : remaining_reg;
    assign skip_after = (skip_reg != 2'd0) ? skip_reg - 2'd1 : skip_reg;

    // phase next state
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_LINE:
            begin
                if (line_done)
                begin
                    if (line_bad)
                    begin
                        phase_next = PH_END;
                    end
                    else if (accum_reg == '0)
                    begin
                        phase_next = PH_TAIL;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
                else if (cap_hit)
                begin
                    phase_next = PH_END;
                end
            end
            PH_DATA:
            begin
                if (rem_after == '0)
                begin
                    phase_next = PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                if (skip_after == 2'd0)
                begin
                    phase_next = PH_LINE;
                end
            end
            PH_TAIL:
            begin
                if (skip_after == 2'd0)
                begin
                    phase_next = PH_END;
                end
            end
            default:
            begin
                phase_next = PH_END;
            end
        endcase
    end

    // datapath updates and result
    always_comb
    begin
        line_count_next = line_count_reg;
        accum_next      = accum_reg;
        parse_next      = parse_reg;
        prev_cr_next    = prev_cr_reg;
        remaining_next  = remaining_reg;
        cur_size_next   = cur_size_reg;
        skip_next       = skip_reg;
        done_next       = done_reg;
        status_next     = ST_FRAMING;
        data_next       = '0;
        unique case (phase_reg)
            PH_LINE:
            begin
                if (line_done || cap_hit)
                begin
                    line_count_next = '0;
                    accum_next      = '0;
                    parse_next      = PARSE_CLR;
                    prev_cr_next    = 1'b0;
                    if (line_done && !line_bad)
                    begin
                        cur_size_next = {1'b0, accum_reg};
                        if (accum_reg == '0)
                        begin
                            skip_next = 2'd2;
                        end
                        else
                        begin
                            remaining_next = accum_reg;
                        end
                    end
                    else
                    begin
                        // rejected line or length cap
                        status_next    = ST_BADLINE;
                        done_next      = 1'b1;
                        cur_size_next  = '0;
                        remaining_next = '0;
                    end
                end
                else
                begin
                    parse_next      = parse_byte;
                    accum_next      = accum_byte;
                    prev_cr_next    = (in_byte == CH_CR);
                    line_count_next = line_n[LINE_W-1:0];
                end
            end
            PH_DATA:
            begin
                status_next    = ST_PAYLOAD;
                data_next      = in_byte;
                remaining_next = rem_after;
                if (rem_after == '0)
                begin
                    skip_next = 2'd2;
                end
            end
            PH_SKIP:
            begin
                skip_next = skip_after;
                if (skip_after == 2'd0)
                begin
                    line_count_next = '0;
                    accum_next      = '0;
                    parse_next      = PARSE_CLR;
                    prev_cr_next    = 1'b0;
                end
            end
            PH_TAIL:
            begin
                skip_next = skip_after;
                if (skip_after == 2'd0)
                begin
                    done_next   = 1'b1;
                    status_next = ST_ENDED;
                end
            end
            default:
            begin
                status_next = ST_IGNORED;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_LINE;
            line_count_reg <= '0;
            accum_reg      <= '0;
            parse_reg      <= PARSE_CLR;
            prev_cr_reg    <= 1'b0;
            remaining_reg  <= '0;
            cur_size_reg   <= '1;
            skip_reg       <= 2'd0;
            done_reg       <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            line_count_reg <= line_count_next;
            accum_reg      <= accum_next;
            parse_reg      <= parse_next;
            prev_cr_reg    <= prev_cr_next;
            remaining_reg  <= remaining_next;
            cur_size_reg   <= cur_size_next;
            skip_reg       <= skip_next;
            done_reg       <= done_next;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    logic [CHUNK_W-1:0] out_size_reg;
    logic               out_ended_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            data_reg      <= data_next;
            out_size_reg  <= cur_size_next;
            out_ended_reg <= done_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_ended_reg, out_size_reg, data_reg, status_reg};

endmodule
